[hw/rtl/etbv_pkg.sv]
// shared types, constants and cordic angle table for the basis vector block
package etbv_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int OUT_FRAC_BITS = 15;
  localparam int CORDIC_STEPS  = 30;
  localparam int CW            = 34;  // cordic x/y/z width
  localparam int QW            = 32;  // clamped q2.30 width

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [QW-1:0] ONE_Q30     = 32'sd1073741824;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_item_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } cordic_t;

  function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

  // rounded q2.30 product
  function automatic logic signed [QW:0] mul30(input logic signed [QW-1:0] a,
                                               input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b + (64'sd1 <<< 29);
    return p[QW+30:30];
  endfunction

  // round to output fraction and saturate
  function automatic logic signed [15:0] to_out(input logic signed [QW+2:0] v);
    localparam int SH = 30 - OUT_FRAC_BITS;
    logic signed [QW+3:0] r;
    if (SH > 0) r = ($signed({v[QW+2], v}) + (36'sd1 <<< (SH - 1))) >>> SH;
    else        r = $signed({v[QW+2], v});
    if (r > 36'sd32767)       return 16'sh7fff;
    else if (r < -36'sd32768) return 16'sh8000;
    else                      return r[15:0];
  endfunction

endpackage

[hw/rtl/etbv_cordic.sv]
// pipelined sine/cosine, one cordic step per stage, stall free
module etbv_cordic import etbv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [15:0]            angle,
  output logic                   out_vld,
  output logic signed [QW-1:0]   sin_q,
  output logic signed [QW-1:0]   cos_q
);

  cordic_t stg_r [CORDIC_STEPS+1];
  logic    vld_r [CORDIC_STEPS+1];
  cordic_t first;
  logic [ANGLE_BITS-1:0] wrapped;
  logic [31:0] ph;
  logic        neg;

  always_comb begin
    wrapped = angle[ANGLE_BITS-1:0];
    ph  = {wrapped, {(32-ANGLE_BITS){1'b0}}};
    neg = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
    if (neg) ph = ph + 32'h80000000;
    first.x   = CORDIC_GAIN;
    first.y   = '0;
    first.z   = $signed({{(CW-32){ph[31]}}, ph});
    first.neg = neg;
  end

  always_ff @(posedge clk) begin
    stg_r[0] <= first;
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cordic_t nxt;
    always_comb begin
      nxt = stg_r[i];
      if (!stg_r[i].z[CW-1]) begin
        nxt.x = stg_r[i].x - (stg_r[i].y >>> i);
        nxt.y = stg_r[i].y + (stg_r[i].x >>> i);
        nxt.z = stg_r[i].z - atan_entry(5'(i));
      end else begin
        nxt.x = stg_r[i].x + (stg_r[i].y >>> i);
        nxt.y = stg_r[i].y - (stg_r[i].x >>> i);
        nxt.z = stg_r[i].z + atan_entry(5'(i));
      end
    end
    always_ff @(posedge clk) begin
      stg_r[i+1] <= nxt;
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_r[i];
    end
  end

  logic signed [CW-1:0] xf, yf;
  logic signed [QW-1:0] sin_r, cos_r;
  logic                 ov_r;

  function automatic logic signed [QW-1:0] clampq(input logic signed [CW-1:0] v);
    if (v > $signed({{(CW-QW){1'b0}}, ONE_Q30}))       return ONE_Q30;
    else if (v < -$signed({{(CW-QW){1'b0}}, ONE_Q30})) return -ONE_Q30;
    else                                                return v[QW-1:0];
  endfunction

  always_comb begin
    xf = stg_r[CORDIC_STEPS].neg ? -stg_r[CORDIC_STEPS].x : stg_r[CORDIC_STEPS].x;
    yf = stg_r[CORDIC_STEPS].neg ? -stg_r[CORDIC_STEPS].y : stg_r[CORDIC_STEPS].y;
  end

  always_ff @(posedge clk) begin
    cos_r <= clampq(xf);
    sin_r <= clampq(yf);
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= vld_r[CORDIC_STEPS];
  end

  assign out_vld = ov_r;
  assign sin_q   = sin_r;
  assign cos_q   = cos_r;

endmodule

[hw/rtl/etbv_matrix.sv]
// three registered product stages and output rounding
module etbv_matrix import etbv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic                 transpose,
  input  logic signed [QW-1:0] sp, cp, sy, cy, sr, cr,
  output logic                 out_vld,
  output out_item_t            out_item
);

  localparam int PW = QW + 1;
  localparam int SW = QW + 3;

  // stage 1: pair products
  logic signed [PW-1:0] spcy_r, spsy_r, cpcy_r, cpsy_r, crsy_r, crcy_r;
  logic signed [PW-1:0] srsy_r, srcy_r, srcp_r, crcp_r, nsp_r;
  logic signed [QW-1:0] sr1_r, cr1_r;
  logic v1_r, t1_r;
  always_ff @(posedge clk) begin
    spcy_r <= mul30(sp, cy);  spsy_r <= mul30(sp, sy);
    cpcy_r <= mul30(cp, cy);  cpsy_r <= mul30(cp, sy);
    crsy_r <= mul30(cr, sy);  crcy_r <= mul30(cr, cy);
    srsy_r <= mul30(sr, sy);  srcy_r <= mul30(sr, cy);
    srcp_r <= mul30(sr, cp);  crcp_r <= mul30(cr, cp);
    nsp_r  <= -$signed({sp[QW-1], sp});
    sr1_r  <= sr;  cr1_r <= cr;  t1_r <= transpose;
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_vld;
  end

  // stage 2: triple products (operands fit q2.30)
  logic signed [PW-1:0] a_r, b_r, c_r, d_r;
  logic signed [PW-1:0] cpcy2_r, cpsy2_r, crsy2_r, crcy2_r, srsy2_r, srcy2_r;
  logic signed [PW-1:0] srcp2_r, crcp2_r, nsp2_r;
  logic v2_r, t2_r;
  always_ff @(posedge clk) begin
    a_r <= mul30(sr1_r, spcy_r[QW-1:0]);  b_r <= mul30(cr1_r, spcy_r[QW-1:0]);
    c_r <= mul30(sr1_r, spsy_r[QW-1:0]);  d_r <= mul30(cr1_r, spsy_r[QW-1:0]);
    cpcy2_r <= cpcy_r; cpsy2_r <= cpsy_r; crsy2_r <= crsy_r; crcy2_r <= crcy_r;
    srsy2_r <= srsy_r; srcy2_r <= srcy_r; srcp2_r <= srcp_r; crcp2_r <= crcp_r;
    nsp2_r <= nsp_r; t2_r <= t1_r;
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] v);
    return SW'(v);
  endfunction

  // stage 3: sums, row selection and rounding
  out_item_t o_nxt, o_r;
  logic      v3_r;
  always_comb begin
    logic signed [SW-1:0] m [9];
    if (!t2_r) begin
      m[0] = ext(cpcy2_r);
      m[1] = ext(cpsy2_r);
      m[2] = ext(nsp2_r);
      m[3] = ext(crsy2_r) - ext(a_r);
      m[4] = -ext(c_r) - ext(crcy2_r);
      m[5] = -ext(srcp2_r);
      m[6] = ext(b_r) + ext(srsy2_r);
      m[7] = ext(d_r) - ext(srcy2_r);
      m[8] = ext(crcp2_r);
    end else begin
      m[0] = ext(cpcy2_r);
      m[1] = ext(a_r) - ext(crsy2_r);
      m[2] = ext(b_r) + ext(srsy2_r);
      m[3] = ext(cpsy2_r);
      m[4] = ext(c_r) + ext(crcy2_r);
      m[5] = ext(d_r) - ext(srcy2_r);
      m[6] = ext(nsp2_r);
      m[7] = ext(srcp2_r);
      m[8] = ext(crcp2_r);
    end
    o_nxt.forward_x = to_out(m[0]);
    o_nxt.forward_y = to_out(m[1]);
    o_nxt.forward_z = to_out(m[2]);
    o_nxt.right_x   = to_out(m[3]);
    o_nxt.right_y   = to_out(m[4]);
    o_nxt.right_z   = to_out(m[5]);
    o_nxt.up_x      = to_out(m[6]);
    o_nxt.up_y      = to_out(m[7]);
    o_nxt.up_z      = to_out(m[8]);
  end

  always_ff @(posedge clk) begin
    o_r <= o_nxt;
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  assign out_vld  = v3_r;
  assign out_item = o_r;

endmodule

[hw/rtl/euler_to_basis_vectors.sv]
// top level: pitch, yaw and roll binary angles to forward, right and up vectors
//
// use of the block
// - input channel: drive in_item and raise start; the transfer happens at a
//   rising edge where start is high and busy is low. busy is always low, so
//   a new item may be given in every cycle
// - result channel: out_valid is high for one cycle with the nine q1.15
//   components on out_item; the receiver cannot hold results off, and none
//   is needed since the pipeline never stalls
// - configuration: cfg_we with cfg_wdata[0] sets transpose_mode; write only
//   while no item is in flight
// - pipeline: from the transfer to out_valid an item passes one fold stage,
//   30 cordic step stages, one clamp stage and three product/sum stages
// - throughput: one item per cycle; set by the fully pipelined cordic
//   and product stages
// - reset: synchronous rst_n clears all valid bits and transpose_mode;
//   items in flight are dropped
module euler_to_basis_vectors import etbv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n)      mode_r <= 1'b0;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  // the pipeline takes a transfer in every cycle
  assign busy = 1'b0;
  logic take;
  assign take = start && !busy;

  logic                 vp, vy, vr;
  logic signed [QW-1:0] sp, cp, sy, cy, sr, cr;

  // one cordic pipeline per angle, all with equal latency
  etbv_cordic u_pitch (.clk, .rst_n, .in_vld(take), .angle(in_item.pitch_angle),
                       .out_vld(vp), .sin_q(sp), .cos_q(cp));
  etbv_cordic u_yaw   (.clk, .rst_n, .in_vld(take), .angle(in_item.yaw_angle),
                       .out_vld(vy), .sin_q(sy), .cos_q(cy));
  etbv_cordic u_roll  (.clk, .rst_n, .in_vld(take), .angle(in_item.roll_angle),
                       .out_vld(vr), .sin_q(sr), .cos_q(cr));

  etbv_matrix u_mat (.clk, .rst_n, .in_vld(vp), .transpose(mode_r),
                     .sp, .cp, .sy, .cy, .sr, .cr,
                     .out_vld(out_valid), .out_item);

`ifndef NO_ASSERTIONS
  // the three angle pipelines stay in step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (vp == vy) && (vp == vr)) else $error("cordic lanes out of step");
  // the pitch sine stays clamped to one
  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    vp |-> (sp <= ONE_Q30) && (sp >= -ONE_Q30)) else $error("sine beyond one");
  // no result rises unless rst_n was already high one pipeline depth earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n, 35)) else $error("result during reset flush");
`endif

endmodule

[dv/euler_to_basis_vectors_test.sv]
// self-checking testbench for the euler angle to basis vector block
module euler_to_basis_vectors_test;
  import etbv_pkg::*;

  localparam int LATENCY     = 35;
  localparam int STALL_LIMIT = 2000;
  localparam int N_RANDOM    = 2000;
  localparam int N_DIRECTED  = 14;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_wdata;

  euler_to_basis_vectors DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the one configuration bit
  logic      pred_transpose;
  out_item_t vectors_due[$];
  int        n_errors;
  int        n_checked;
  int        n_sent;
  int        quiet_cycles;

  // directed table: angles, mode, and whether the expected vectors are typed in
  typedef struct {
    logic signed [15:0] p, y, r;
    logic               mode;
    logic               typed;
    out_item_t          want;
  } dir_row_t;
  dir_row_t dir_rows[N_DIRECTED];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // binary angle to sine/cosine in q2.30 via folded rotation cordic
  function automatic void angle_sincos(input logic [15:0] ang, output longint s,
                                       output longint c);
    logic [31:0] ph;
    logic        flip;
    longint      x, yy, z, t, step_atan;
    ph   = {ang, 16'h0000};
    flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
    if (flip) ph = ph + 32'h8000_0000;
    z  = longint'($signed(ph));
    x  = 652032874;
    yy = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      step_atan = longint'(atan_entry(i[4:0]));
      if (z >= 0) begin
        t  = x - shr_floor(yy, i);
        yy = yy + shr_floor(x, i);
        z  = z - step_atan;
      end else begin
        t  = x + shr_floor(yy, i);
        yy = yy - shr_floor(x, i);
        z  = z + step_atan;
      end
      x = t;
    end
    if (flip) begin
      x  = -x;
      yy = -yy;
    end
    c = (x < -64'sd1073741824) ? -64'sd1073741824 : (x > 64'sd1073741824 ? 64'sd1073741824 : x);
    s = (yy < -64'sd1073741824) ? -64'sd1073741824 : (yy > 64'sd1073741824 ? 64'sd1073741824 : yy);
  endfunction

  function automatic longint q30_product(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [15:0] q30_to_q15(longint v);
    longint r;
    r = (v + (64'sd1 <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  function automatic out_item_t basis_vectors(in_item_t a, logic mode);
    longint sp, cp, sy, cy, sr, cr, spcy, spsy, ta, tb, tc, td;
    longint m[9];
    out_item_t o;
    angle_sincos(a.pitch_angle, sp, cp);
    angle_sincos(a.yaw_angle, sy, cy);
    angle_sincos(a.roll_angle, sr, cr);
    spcy = q30_product(sp, cy);
    spsy = q30_product(sp, sy);
    ta = q30_product(sr, spcy);
    tb = q30_product(cr, spcy);
    tc = q30_product(sr, spsy);
    td = q30_product(cr, spsy);
    if (!mode) begin
      m[0] = q30_product(cp, cy);
      m[1] = q30_product(cp, sy);
      m[2] = -sp;
      m[3] = -ta + q30_product(cr, sy);
      m[4] = -tc - q30_product(cr, cy);
      m[5] = -q30_product(sr, cp);
      m[6] = tb + q30_product(sr, sy);
      m[7] = td - q30_product(sr, cy);
      m[8] = q30_product(cr, cp);
    end else begin
      m[0] = q30_product(cp, cy);
      m[1] = ta - q30_product(cr, sy);
      m[2] = tb + q30_product(sr, sy);
      m[3] = q30_product(cp, sy);
      m[4] = tc + q30_product(cr, cy);
      m[5] = td - q30_product(sr, cy);
      m[6] = -sp;
      m[7] = q30_product(sr, cp);
      m[8] = q30_product(cr, cp);
    end
    o.forward_x = q30_to_q15(m[0]);
    o.forward_y = q30_to_q15(m[1]);
    o.forward_z = q30_to_q15(m[2]);
    o.right_x   = q30_to_q15(m[3]);
    o.right_y   = q30_to_q15(m[4]);
    o.right_z   = q30_to_q15(m[5]);
    o.up_x      = q30_to_q15(m[6]);
    o.up_y      = q30_to_q15(m[7]);
    o.up_z      = q30_to_q15(m[8]);
    return o;
  endfunction

  // result monitor: every strobe is compared with the oldest expectation
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid) begin
      quiet_cycles <= 0;
      if (vectors_due.size() == 0) begin
        $error("result with no expectation waiting");
        n_errors++;
      end else begin
        w = vectors_due.pop_front();
        n_checked++;
        if (out_item.forward_x !== w.forward_x) begin
          $error("forward_x exp %0d got %0d", w.forward_x, out_item.forward_x); n_errors++;
        end
        if (out_item.forward_y !== w.forward_y) begin
          $error("forward_y exp %0d got %0d", w.forward_y, out_item.forward_y); n_errors++;
        end
        if (out_item.forward_z !== w.forward_z) begin
          $error("forward_z exp %0d got %0d", w.forward_z, out_item.forward_z); n_errors++;
        end
        if (out_item.right_x !== w.right_x) begin
          $error("right_x exp %0d got %0d", w.right_x, out_item.right_x); n_errors++;
        end
        if (out_item.right_y !== w.right_y) begin
          $error("right_y exp %0d got %0d", w.right_y, out_item.right_y); n_errors++;
        end
        if (out_item.right_z !== w.right_z) begin
          $error("right_z exp %0d got %0d", w.right_z, out_item.right_z); n_errors++;
        end
        if (out_item.up_x !== w.up_x) begin
          $error("up_x exp %0d got %0d", w.up_x, out_item.up_x); n_errors++;
        end
        if (out_item.up_y !== w.up_y) begin
          $error("up_y exp %0d got %0d", w.up_y, out_item.up_y); n_errors++;
        end
        if (out_item.up_z !== w.up_z) begin
          $error("up_z exp %0d got %0d", w.up_z, out_item.up_z); n_errors++;
        end
      end
    end else if (start && !busy) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on cycles with neither an input nor a result transfer
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL euler_to_basis_vectors");
        $finish;
      end
    end
  end

  // hold one item on the inputs until it transfers; the expectation is logged then
  task automatic send_angles(input in_item_t a, input out_item_t want, input logic typed);
    @(negedge clk);
    in_item = a;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    vectors_due.push_back(typed ? want : basis_vectors(a, pred_transpose));
    n_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // wait until the pipeline has drained before touching the register
  task automatic set_transpose(input logic mode);
    while (vectors_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = mode;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    pred_transpose = mode;
  endtask

  function automatic logic signed [15:0] random_angle(int kind);
    case (kind)
      0: return 16'(($urandom_range(0, 7) << 13) + $urandom_range(0, 6) - 3);
      1: return 16'sh8000;
      2: return 16'sh7fff;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    in_item_t  a;
    out_item_t want;
    int        kind;
    bit        steady;
    n_errors = 0; n_checked = 0; n_sent = 0; quiet_cycles = 0;
    pred_transpose = 1'b0;
    rst_n = 1'b0; start = 1'b0; in_item = '0; cfg_we = 1'b0; cfg_wdata = 1'b0;

    // zero angles give identity, with the sign flip on the right row
    want = '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0,
             16'sd0, 16'sd0, 16'sd32767};
    dir_rows[0] = '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, want};
    dir_rows[1] = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b0, '0};
    dir_rows[2] = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 1'b0, '0};
    dir_rows[3] = '{16'sh4000, 16'sd0, 16'sd0, 1'b0, 1'b0, '0};
    dir_rows[4] = '{16'shc000, 16'sh4000, 16'sh2000, 1'b0, 1'b0, '0};
    dir_rows[5] = '{16'sh2000, 16'shc000, 16'sh8000, 1'b0, 1'b0, '0};
    dir_rows[6] = '{16'sh5555, 16'shaaaa, 16'shffff, 1'b0, 1'b0, '0};
    dir_rows[7] = '{16'sd1, 16'sd1, 16'sd1, 1'b0, 1'b0, '0};
    dir_rows[8] = '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1,
                    '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0,
                      16'sd0, 16'sd0, 16'sd32767}};
    dir_rows[9]  = '{16'sh8000, 16'sh7fff, 16'sh4000, 1'b1, 1'b0, '0};
    dir_rows[10] = '{16'sh3fff, 16'shbfff, 16'sh4001, 1'b1, 1'b0, '0};
    dir_rows[11] = '{16'sh6000, 16'sh1000, 16'she000, 1'b1, 1'b0, '0};
    dir_rows[12] = '{16'shffff, 16'sh0001, 16'sh8001, 1'b1, 1'b0, '0};
    dir_rows[13] = '{16'sh1234, 16'shedcb, 16'sh7654, 1'b1, 1'b0, '0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (dir_rows[i].mode != pred_transpose) set_transpose(dir_rows[i].mode);
      a = '{dir_rows[i].p, dir_rows[i].y, dir_rows[i].r};
      send_angles(a, dir_rows[i].want, dir_rows[i].typed);
    end

    // random part in phases, the mode toggled between them
    for (int ph = 0; ph < 6; ph++) begin
      set_transpose(ph[0] ? 1'b0 : 1'b1);
      steady = (ph == 2);
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        // each idle cycle holds start low
        if (!steady) begin
          while ($urandom_range(0, 99) < 38) begin
            @(negedge clk);
            start = 1'b0;
          end
        end
        kind = $urandom_range(0, 9);
        a.pitch_angle = random_angle(kind < 3 ? kind : 3);
        a.yaw_angle   = random_angle($urandom_range(0, 9) < 2 ? 0 : 3);
        a.roll_angle  = random_angle($urandom_range(0, 9) < 2 ? 0 : 3);
        // back-to-back transfers: keep start high and swap data at the falling edge
        @(negedge clk);
        in_item = a;
        start   = 1'b1;
        do @(posedge clk); while (busy);
        vectors_due.push_back(basis_vectors(a, pred_transpose));
        n_sent++;
      end
      @(negedge clk);
      start = 1'b0;
    end

    while (vectors_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    $display("covered %0d angle triples, %0d results checked, both matrix modes",
             n_sent, n_checked);
    if (n_errors == 0 && vectors_due.size() == 0) begin
      $display("PASS euler_to_basis_vectors");
    end else begin
      $display("FAIL euler_to_basis_vectors");
    end
    $finish;
  end

endmodule

[euler_to_basis_vectors.f]
hw/rtl/etbv_pkg.sv
hw/rtl/etbv_cordic.sv
hw/rtl/etbv_matrix.sv
hw/rtl/euler_to_basis_vectors.sv
dv/euler_to_basis_vectors_test.sv
